// File: rtl/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg: shared types and constants for the sorted alarm timer queue
// Operation and result codes, cell control struct, register indexes.
// ----------------------------------------------------------------------------
package satq_pkg;

  localparam int unsigned TimeBits = 64;
  localparam int unsigned FreqBits = 32;

  typedef enum logic [2:0] {
    OP_ARM_ABS  = 3'd0,
    OP_ARM_SEC  = 3'd1,
    OP_ARM_MSEC = 3'd2,
    OP_ARM_USEC = 3'd3,
    OP_TICK     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_RELEASED = 2'd0,
    KIND_COMPARE  = 2'd1,
    KIND_QUEUED   = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_WAKE,
    ST_ARM,
    ST_INSERT,
    ST_TICK,
    ST_POP,
    ST_TICK_CMP,
    ST_OUT
  } state_e;

  localparam logic CfgFreq    = 1'b0;
  localparam logic CfgPreempt = 1'b1;

  // control broadcast to every cell in the chain
  typedef struct packed {
    logic             insert;   // the slot takes the new alarm, cells past it shift right
    logic             shift;    // every cell takes its right neighbour
    logic [TimeBits-1:0] wake;  // compare key for insertion
  } cell_ctrl_t;

endpackage

// File: rtl/satq_cell.sv
// ----------------------------------------------------------------------------
// satq_cell: one slot of the sorted alarm chain
// Holds a wake time and tag; inserts, shifts right or pops left.
// ----------------------------------------------------------------------------
module satq_cell #(
  parameter int unsigned TagBits = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  satq_pkg::cell_ctrl_t          ctrl_i,
  input  logic [TagBits-1:0]            ins_tag_i,
  // left neighbour (towards head)
  input  logic                          left_full_i,
  input  logic                          left_goes_i,
  input  logic [satq_pkg::TimeBits-1:0] left_wake_i,
  input  logic [TagBits-1:0]            left_tag_i,
  // right neighbour (towards tail)
  input  logic                          right_full_i,
  input  logic [satq_pkg::TimeBits-1:0] right_wake_i,
  input  logic [TagBits-1:0]            right_tag_i,
  output logic                          full_o,
  output logic                          goes_o,
  output logic [satq_pkg::TimeBits-1:0] wake_o,
  output logic [TagBits-1:0]            tag_o
);
  import satq_pkg::*;

  logic                full_q, full_d;
  logic [TimeBits-1:0] wake_q, wake_d;
  logic [TagBits-1:0]  tag_q, tag_d;

  // this slot sits after the new alarm: later wake time, or empty
  assign goes_o = !full_q || (wake_q > ctrl_i.wake);
  assign full_o = full_q;
  assign wake_o = wake_q;
  assign tag_o  = tag_q;

  always_comb begin
    full_d = full_q;
    wake_d = wake_q;
    tag_d  = tag_q;
    if (ctrl_i.insert) begin
      if (goes_o) begin
        if (left_goes_i) begin
          full_d = left_full_i;
          wake_d = left_wake_i;
          tag_d  = left_tag_i;
        end else begin
          full_d = 1'b1;
          wake_d = ctrl_i.wake;
          tag_d  = ins_tag_i;
        end
      end
    end else if (ctrl_i.shift) begin
      full_d = right_full_i;
      wake_d = right_wake_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
    tag_q  <= tag_d;
  end

endmodule

// File: rtl/satq_scale.sv
// ----------------------------------------------------------------------------
// satq_scale: relative delay scaler
// amount * freq / d, saturated, via two 32x32 products and a byte-wise
// reciprocal divide by the unit.
// ----------------------------------------------------------------------------
module satq_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    unit_i,   // 1 sec, 2 msec, 3 usec
  input  logic [satq_pkg::TimeBits-1:0] amount_i,
  input  logic [satq_pkg::FreqBits-1:0] freq_i,
  output logic                          done_o,
  output logic [satq_pkg::TimeBits-1:0] delay_o
);
  import satq_pkg::*;

  localparam int unsigned ProdBits  = 96;
  localparam int unsigned DigitBits = 8;
  localparam int unsigned RemBits   = 20;
  localparam int unsigned NumBits   = RemBits + DigitBits;
  localparam int unsigned MsBits    = 18;   // numerator bits when the unit is 1000
  localparam int unsigned CntBits   = 4;
  localparam logic [RemBits-1:0] DivMs = 20'd1000;
  localparam logic [RemBits-1:0] DivUs = 20'd1000000;
  // floor(x / d) as (x * m) >> k, exact over each numerator range
  localparam logic [18:0] RecipMs = 19'd268436;      // ceil(2^28 / 1000)
  localparam int unsigned ShiftMs = 28;
  localparam logic [28:0] RecipUs = 29'd281474977;   // ceil(2^48 / 1000000)
  localparam int unsigned ShiftUs = 48;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL_HI,
    SC_DIV,
    SC_DONE
  } sc_state_e;

  sc_state_e            st_q, st_d;
  logic [ProdBits-1:0]  prod_q, prod_d;   // dividend shifts out of the top
  logic [1:0]           unit_q, unit_d;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [ProdBits-1:0]  quo_q, quo_d;
  logic [DigitBits-1:0] qdig_q, qdig_d;
  logic                 ph_q, ph_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [31:0]          amt_hi_q, amt_hi_d;
  logic [FreqBits-1:0]  freq_q, freq_d;
  logic [63:0]          mul_lo;
  logic [63:0]          mul_hi;
  logic [NumBits-1:0]   num;
  logic [36:0]          rec_ms;
  logic [56:0]          rec_us;
  logic [DigitBits-1:0] qdig;
  logic [NumBits-1:0]   qmul;

  assign mul_lo = {32'd0, amount_i[31:0]} * {32'd0, freq_i};
  assign mul_hi = {32'd0, amt_hi_q} * {32'd0, freq_q};
  // partial remainder followed by the next byte of the product
  assign num    = {rem_q, prod_q[ProdBits-1 -: DigitBits]};
  assign rec_ms = {19'd0, num[MsBits-1:0]} * {18'd0, RecipMs};
  assign rec_us = {29'd0, num} * {28'd0, RecipUs};

  always_comb begin
    unique case (unit_q)
      2'd2: begin
        qdig = rec_ms[ShiftMs +: DigitBits];
        qmul = NumBits'(qdig_q) * NumBits'(DivMs);
      end
      2'd3: begin
        qdig = rec_us[ShiftUs +: DigitBits];
        qmul = NumBits'(qdig_q) * NumBits'(DivUs);
      end
      default: begin
        qdig = num[DigitBits-1:0];
        qmul = NumBits'(qdig_q);
      end
    endcase
  end

  always_comb begin
    st_d     = st_q;
    prod_d   = prod_q;
    unit_d   = unit_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    qdig_d   = qdig_q;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    amt_hi_d = amt_hi_q;
    freq_d   = freq_q;
    unique case (st_q)
      SC_IDLE: begin
        if (start_i) begin
          prod_d   = {32'd0, mul_lo};
          amt_hi_d = amount_i[63:32];
          freq_d   = freq_i;
          unit_d   = unit_i;
          st_d     = SC_MUL_HI;
        end
      end
      SC_MUL_HI: begin
        prod_d = prod_q + {mul_hi, 32'd0};
        rem_d  = '0;
        quo_d  = '0;
        ph_d   = 1'b0;
        cnt_d  = CntBits'(ProdBits / DigitBits);
        st_d   = SC_DIV;
      end
      SC_DIV: begin
        // per quotient byte: pick the digit, then subtract and shift it in
        if (!ph_q) begin
          qdig_d = qdig;
          ph_d   = 1'b1;
        end else begin
          rem_d  = RemBits'(num - qmul);
          quo_d  = {quo_q[ProdBits-DigitBits-1:0], qdig_q};
          prod_d = {prod_q[ProdBits-DigitBits-1:0], {DigitBits{1'b0}}};
          cnt_d  = cnt_q - 1'b1;
          ph_d   = 1'b0;
          if (cnt_q == CntBits'(1)) begin
            st_d = SC_DONE;
          end
        end
      end
      default: begin
        st_d = SC_IDLE;
      end
    endcase
  end

  assign done_o  = (st_q == SC_DONE);
  assign delay_o = (quo_q[ProdBits-1:64] != '0) ? '1 : quo_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SC_IDLE;
      cnt_q <= '0;
      ph_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ph_q  <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    unit_q   <= unit_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    qdig_q   <= qdig_d;
    amt_hi_q <= amt_hi_d;
    freq_q   <= freq_d;
  end

endmodule

// File: rtl/sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue: alarm queue kept sorted in a chain of cells
// Arms alarms by absolute or scaled relative time, releases expired ones.
// ----------------------------------------------------------------------------
// Absolute arm: the wake time is set in ST_WAKE, the new alarm is compared
// against every cell in ST_ARM and, if it enters the chain, shifted in by
// ST_INSERT; the result word follows in ST_OUT. Relative arm first passes
// ST_MUL_LO, ST_MUL_HI and ST_DIV: two product steps and a byte-wise divide by
// the unit. Tick: each expired alarm is popped from the chain head in ST_POP
// and its word given in ST_OUT; then ST_TICK_CMP gives the compare word.
// One item at a time. Reset empties the chain and loads register defaults.
module sorted_alarm_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op_i,
  input  logic [63:0]          now_i,
  input  logic [63:0]          amount_i,
  input  logic [7:0]           waiter_tag_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind_o,
  output logic [7:0]           tag_o,
  output logic [63:0]          compare_time_o,
  output logic                 last_o,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import satq_pkg::*;

  localparam int unsigned N = QUEUE_DEPTH;

  state_e              st_q, st_d;
  logic [FreqBits-1:0] freq_q, preempt_q;
  logic [2:0]          op_q;
  logic [63:0]         now_q, amount_q, wake_q, wake_d;
  logic [TAG_BITS-1:0] itag_q;
  logic [1:0]          okind_q, okind_d;
  logic [7:0]          otag_q, otag_d;
  logic [63:0]         ocmp_q, ocmp_d;
  logic                olast_q, olast_d;
  state_e              ret_q, ret_d;
  logic                op_q_rel;
  logic                scale_start, scale_done;
  logic [63:0]         delay;
  logic [64:0]         wsum, psum;
  cell_ctrl_t          ctrl;

  logic                full   [N+1];
  logic                goes   [N];
  logic [63:0]         cwake  [N+1];
  logic [TAG_BITS-1:0] ctag   [N+1];

  assign cfg_ready = (st_q == ST_IDLE);
  assign in_stall  = (st_q != ST_IDLE);
  assign out_valid = (st_q == ST_OUT);
  assign kind_o         = okind_q;
  assign tag_o          = otag_q;
  assign compare_time_o = ocmp_q;
  assign last_o         = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q    <= 32'd10000000;
      preempt_q <= 32'd200000;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index_i == CfgFreq) begin
        freq_q <= cfg_data_i;
      end else begin
        preempt_q <= cfg_data_i;
      end
    end
  end

  satq_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scale_start),
    .unit_i   (op_q[1:0]),
    .amount_i (amount_q),
    .freq_i   (freq_q),
    .done_o   (scale_done),
    .delay_o  (delay)
  );

  // chain boundaries: the slot past the tail is always empty
  assign full[N]  = 1'b0;
  assign cwake[N] = '0;
  assign ctag[N]  = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                lf, lg;
    logic [63:0]         lw;
    logic [TAG_BITS-1:0] lt;
    if (g == 0) begin : g_head
      assign lf = 1'b0;
      assign lg = 1'b0;
      assign lw = '0;
      assign lt = '0;
    end else begin : g_body
      assign lf = full[g-1];
      assign lg = goes[g-1];
      assign lw = cwake[g-1];
      assign lt = ctag[g-1];
    end
    satq_cell #(.TagBits(TAG_BITS)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .ins_tag_i    (itag_q),
      .left_full_i  (lf),
      .left_goes_i  (lg),
      .left_wake_i  (lw),
      .left_tag_i   (lt),
      .right_full_i (full[g+1]),
      .right_wake_i (cwake[g+1]),
      .right_tag_i  (ctag[g+1]),
      .full_o       (full[g]),
      .goes_o       (goes[g]),
      .wake_o       (cwake[g]),
      .tag_o        (ctag[g])
    );
  end

  assign op_q_rel = (op_q == 3'(OP_ARM_SEC)) || (op_q == 3'(OP_ARM_MSEC)) ||
                    (op_q == 3'(OP_ARM_USEC));
  assign scale_start = (st_q == ST_MUL_LO);
  assign wsum = {1'b0, now_q} + {1'b0, delay};
  assign psum = {1'b0, now_q} + {33'd0, preempt_q};

  // next state and datapath
  always_comb begin
    st_d    = st_q;
    wake_d  = wake_q;
    okind_d = okind_q;
    otag_d  = otag_q;
    ocmp_d  = ocmp_q;
    olast_d = olast_q;
    ret_d   = ret_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid) begin
          if (op_i == 3'(OP_TICK)) begin
            st_d = ST_TICK;
          end else if (op_i == 3'(OP_ARM_ABS)) begin
            st_d = ST_WAKE;
          end else if (op_i < 3'(OP_TICK)) begin
            st_d = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: st_d = ST_MUL_HI;
      ST_MUL_HI, ST_DIV: begin
        st_d = ST_DIV;
        if (scale_done) begin
          st_d = ST_WAKE;
        end
      end
      ST_WAKE: begin
        wake_d = op_q_rel ? (wsum[64] ? '1 : wsum[63:0]) : amount_q;
        st_d   = ST_ARM;
      end
      ST_ARM: begin
        olast_d = 1'b1;
        otag_d  = 8'(itag_q);
        ocmp_d  = '0;
        ret_d   = ST_IDLE;
        st_d    = ST_OUT;
        if (wake_q <= now_q) begin
          okind_d = KIND_RELEASED;
        end else if (full[N-1]) begin
          okind_d = KIND_REJECTED;
        end else begin
          st_d = ST_INSERT;
          if (goes[0]) begin
            okind_d = KIND_COMPARE;
            otag_d  = '0;
            ocmp_d  = wake_q;
          end else begin
            okind_d = KIND_QUEUED;
          end
        end
      end
      ST_INSERT: st_d = ST_OUT;
      ST_TICK: begin
        if (full[0] && (cwake[0] <= now_q)) begin
          okind_d = KIND_RELEASED;
          otag_d  = 8'(ctag[0]);
          ocmp_d  = '0;
          olast_d = 1'b0;
          ret_d   = ST_TICK;
          st_d    = ST_POP;
        end else begin
          st_d = ST_TICK_CMP;
        end
      end
      ST_POP: st_d = ST_OUT;
      ST_TICK_CMP: begin
        okind_d = KIND_COMPARE;
        otag_d  = '0;
        olast_d = 1'b1;
        ret_d   = ST_IDLE;
        ocmp_d  = psum[64] ? '1 : psum[63:0];
        if (full[0] && (cwake[0] < ocmp_d)) begin
          ocmp_d = cwake[0];
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          st_d = ret_q;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // chain control
  always_comb begin
    ctrl.insert = (st_q == ST_INSERT);
    ctrl.shift  = (st_q == ST_POP);
    ctrl.wake   = wake_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      ret_q <= ST_IDLE;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid) begin
      op_q     <= op_i;
      now_q    <= now_i;
      amount_q <= amount_i;
      itag_q   <= waiter_tag_i[TAG_BITS-1:0];
    end
    wake_q  <= wake_d;
    okind_q <= okind_d;
    otag_q  <= otag_d;
    ocmp_q  <= ocmp_d;
    olast_q <= olast_d;
  end

endmodule

// File: tb/tb_sorted_alarm_timer_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_alarm_timer_queue: self-checking bench for the sorted alarm queue
// Drives arm, tick and spare operations under several idle and stall mixes,
// predicts every result word from a model of the sorted queue, and checks
// each output word in order against that prediction.
// ----------------------------------------------------------------------------
module tb_sorted_alarm_timer_queue;
  import satq_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam logic [2:0]  OpSpareLo = 3'd5;
  localparam logic [2:0]  OpSpareHi = 3'd7;
  localparam logic [63:0] TimeMax   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned SettleCyc = 300;
  localparam int unsigned StuckLimit = 5000;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag;
    logic [63:0] cmp;
    logic        last;
  } alarm_word_t;

  class alarm_scoreboard;
    logic [63:0]  wake_q [Depth];
    logic [7:0]   tag_q [Depth];
    int unsigned  count;
    logic [31:0]  freq;
    logic [31:0]  preempt;
    alarm_word_t  due_words [$];
    int unsigned  mismatches;

    function new();
      count = 0;
      freq = 32'd10000000;
      preempt = 32'd200000;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CfgFreq) freq = val;
      else preempt = val;
    endfunction

    // floor(amount * freq / unit), saturated
    function logic [63:0] scaled_delay(logic [63:0] amount, logic [127:0] unit);
      logic [127:0] prod;
      prod = ({64'd0, amount} * {96'd0, freq}) / unit;
      return (prod[127:64] != 0) ? TimeMax : prod[63:0];
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? TimeMax : s[63:0];
    endfunction

    function void push_word(kind_e k, logic [7:0] t, logic [63:0] c);
      alarm_word_t w;
      w.kind = k;
      w.tag = t;
      w.cmp = c;
      w.last = 1'b0;
      due_words.push_back(w);
    endfunction

    function void note_input(logic [2:0] op, logic [63:0] now, logic [63:0] amount,
                             logic [7:0] tag);
      logic [63:0] wake;
      logic [63:0] next;
      int unsigned pos;
      int unsigned done;
      if (op > OP_TICK) return;
      if (op == OP_TICK) begin
        done = 0;
        while (done < count && wake_q[done] <= now) begin
          push_word(KIND_RELEASED, tag_q[done], '0);
          done++;
        end
        for (int i = done; i < count; i++) begin
          wake_q[i - done] = wake_q[i];
          tag_q[i - done] = tag_q[i];
        end
        count -= done;
        next = sat_sum(now, {32'd0, preempt});
        if (count > 0 && wake_q[0] < next) next = wake_q[0];
        push_word(KIND_COMPARE, '0, next);
      end else begin
        case (op)
          OP_ARM_ABS:  wake = amount;
          OP_ARM_SEC:  wake = sat_sum(now, scaled_delay(amount, 1));
          OP_ARM_MSEC: wake = sat_sum(now, scaled_delay(amount, 1000));
          default:     wake = sat_sum(now, scaled_delay(amount, 1000000));
        endcase
        if (wake <= now) begin
          push_word(KIND_RELEASED, tag, '0);
        end else if (count >= Depth) begin
          push_word(KIND_REJECTED, tag, '0);
        end else begin
          pos = 0;
          while (pos < count && wake_q[pos] <= wake) pos++;
          for (int i = count; i > pos; i--) begin
            wake_q[i] = wake_q[i - 1];
            tag_q[i] = tag_q[i - 1];
          end
          wake_q[pos] = wake;
          tag_q[pos] = tag;
          count++;
          if (pos == 0) push_word(KIND_COMPARE, '0, wake);
          else push_word(KIND_QUEUED, tag, '0);
        end
      end
      due_words[$].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] tag, logic [63:0] cmp,
                               logic last);
      alarm_word_t w;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word kind=%0d tag=%0d cmp=%h last=%0b",
                   kind, tag, cmp, last);
        return;
      end
      w = due_words.pop_front();
      if (kind !== w.kind || tag !== w.tag || cmp !== w.cmp || last !== w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: exp kind=%0d tag=%0d cmp=%h last=%0b, ",
                    "got kind=%0d tag=%0d cmp=%h last=%0b"},
                   w.kind, w.tag, w.cmp, w.last, kind, tag, cmp, last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op_i;
  logic [63:0] now_i;
  logic [63:0] amount_i;
  logic [7:0]  waiter_tag_i;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind_o;
  logic [7:0]  tag_o;
  logic [63:0] compare_time_o;
  logic        last_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  alarm_scoreboard alarms = new();
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  logic        hold_req = 1'b0;
  int unsigned stuck_cycles;
  logic [63:0] clock_now;

  sorted_alarm_timer_queue uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    op_i = '0;
    now_i = '0;
    amount_i = '0;
    waiter_tag_i = '0;
    cfg_valid = 1'b0;
    cfg_index_i = CfgFreq;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver side: checks words, stalls at random or for a long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        alarms.check_result(kind_o, tag_o, compare_time_o, last_o);
      if (hold_req && hold_cycles == 0) hold_cycles = 400;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(logic [2:0] op, logic [63:0] now, logic [63:0] amount,
                           logic [7:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= op;
    now_i <= now;
    amount_i <= amount;
    waiter_tag_i <= tag;
    do @(posedge clk_i); while (in_stall);
    alarms.note_input(op, now, amount, tag);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (alarms.due_words.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alarms.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // mostly near-future alarms around a running time, some full-range noise
  task automatic random_word();
    logic [2:0]  op;
    logic [63:0] amount;
    logic [63:0] now;
    int unsigned pick;
    clock_now = clock_now + $urandom_range(40000);
    now = clock_now;
    pick = $urandom_range(99);
    op = (pick < 30) ? OP_TICK : 3'($urandom_range(OP_ARM_USEC));
    case (op)
      OP_ARM_ABS:  amount = clock_now - 2000 + $urandom_range(400000);
      OP_ARM_SEC:  amount = $urandom_range(2);
      OP_ARM_MSEC: amount = $urandom_range(60);
      default:     amount = $urandom_range(60000);
    endcase
    if (pick >= 95) begin
      now = {$urandom, $urandom};
      amount = {$urandom, $urandom};
      if (pick == 99) op = 3'($urandom_range(OpSpareLo, OpSpareHi));
    end
    send_word(op, now, amount, 8'($urandom));
  endtask

  initial begin
    clock_now = 64'd1000;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: release at once, equal wake times, new head, units, saturation
    send_word(OP_ARM_ABS, 64'd1000, 64'd0, 8'h00);
    send_word(OP_ARM_ABS, 64'd1000, 64'd1000, 8'hFF);
    send_word(OP_ARM_ABS, 64'd1000, 64'd5000, 8'h01);
    send_word(OP_ARM_ABS, 64'd1000, 64'd5000, 8'h02);
    send_word(OP_ARM_ABS, 64'd1000, 64'd3000, 8'h03);
    send_word(OP_ARM_SEC, 64'd1000, 64'd1, 8'h04);
    send_word(OP_ARM_MSEC, 64'd1000, 64'd1, 8'h05);
    send_word(OP_ARM_USEC, 64'd1000, 64'd1, 8'h06);
    send_word(OP_ARM_USEC, 64'd1000, 64'd0, 8'h07);
    send_word(OP_ARM_SEC, 64'd1000, TimeMax, 8'h08);
    send_word(OP_ARM_MSEC, TimeMax - 5, 64'd1000, 8'h09);
    for (int op = OpSpareLo; op <= OpSpareHi; op++)
      send_word(3'(op), TimeMax, TimeMax, 8'hAA);
    send_word(OP_TICK, 64'd6000, '0, '0);
    send_word(OP_TICK, TimeMax, '0, '0);
    // fill to the brim, one rejected, then release everything in one tick
    for (int i = 0; i <= Depth; i++)
      send_word(OP_ARM_ABS, 64'd0, TimeMax - (i % 3), 8'(i + 16));
    send_word(OP_TICK, TimeMax, '0, '0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgFreq, 32'd10000000);
          write_reg(CfgPreempt, 32'd200000);
        end
        1: begin
          write_reg(CfgFreq, 32'd1);
          write_reg(CfgPreempt, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(CfgFreq, 32'hFFFF_FFFF);
          write_reg(CfgPreempt, 32'd1);
        end
        default: begin
          write_reg(CfgFreq, $urandom_range(32'd1, 32'd50000000));
          write_reg(CfgPreempt, $urandom);
        end
      endcase
      idle_pct  = (phase == 1) ? 78 : (phase == 3) ? 38 : 0;
      stall_pct = (phase == 2) ? 78 : (phase == 3) ? 38 : 0;
      if (phase == 2) hold_req <= 1'b1;
      for (int n = 0; n < 47; n++) begin
        if (n == 1) hold_req <= 1'b0;
        random_word();
      end
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    if (alarms.mismatches == 0 && alarms.due_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
